>>> rtl/signed_number_to_seven_segment_core_macros.svh
// Assertion macros shared by the seven-segment encoder RTL.
`ifndef SIGNED_NUMBER_TO_SEVEN_SEGMENT_CORE_MACROS_SVH
`define SIGNED_NUMBER_TO_SEVEN_SEGMENT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and disabled while in reset.
`define SSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seven-segment encoder check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define SSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seven-segment encoder check failed");

`else

`define SSD_ASSERT_NOW(label, ante, cons)
`define SSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/ssd_pkg.sv
// Types, constants and the digit table of the seven-segment encoder.
package ssd_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_BLANK_LEADING_ZEROS = 2'd0;
    localparam logic [1:0] REG_ALL_POINTS          = 2'd1;
    localparam logic [1:0] REG_DP_POSITION         = 2'd2;

    // Decimal-point position code that means no extra point.
    localparam logic [1:0] DP_NONE = 2'd3;

    // Segment patterns in XGFEDCBA order.
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;

    // Magnitude width: in-range values never exceed 9999.
    localparam int MAG_W  = 14;
    localparam int PROD_W = 29;

    // Reciprocals for division by constants, exact for magnitudes below 10000.
    localparam logic [14:0] RECIP_1000 = 15'd16778;  // shift by 24
    localparam logic [12:0] RECIP_100  = 13'd5243;   // shift by 19
    localparam logic [12:0] RECIP_10   = 13'd6554;   // shift by 16

    // Configuration registers as one group.
    typedef struct packed {
        logic       blank_leading_zeros;
        logic       all_points;
        logic [1:0] dp_position;
    } ssd_cfg_t;

    // One result word.
    typedef struct packed {
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_fourth;
        logic       out_of_range;
    } ssd_result_t;

    // Decimal digit to segment pattern; codes above nine show nothing.
    function automatic logic [7:0] digit_to_seg(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/signed_number_to_seven_segment_core.sv
// Top level of the four-digit seven-segment encoder for signed numbers.
// Path: a number accepted into the input register is converted and moves on
// into the result register when that register is empty or its word is taken.
// Throughput: one word per cycle while out_stall is low; conversion is one
// combinational pass between the input register and the result register.
// Reset: clears both valid bits; configuration returns to blanking on,
// all points on and no extra decimal point.
`include "signed_number_to_seven_segment_core_macros.svh"

module signed_number_to_seven_segment_core (
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    // Input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [15:0] number,
    // Output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        seg_first,
    output logic [7:0]        seg_second,
    output logic [7:0]        seg_third,
    output logic [7:0]        seg_fourth,
    output logic              out_of_range
);
    import ssd_pkg::*;

    ssd_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic signed [15:0] number_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    ssd_result_t       result_reg;
    ssd_result_t       result_next;
    logic              in_load;
    logic              out_load;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_leading_zeros <= 1'b1;
            cfg_reg.all_points          <= 1'b1;
            cfg_reg.dp_position         <= DP_NONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLANK_LEADING_ZEROS: cfg_reg.blank_leading_zeros <= cfg_data[0];
                REG_ALL_POINTS:          cfg_reg.all_points          <= cfg_data[0];
                REG_DP_POSITION:         cfg_reg.dp_position         <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Stage handshake: the result stage moves when empty or taken downstream.
    assign out_load = !out_valid_reg || !out_stall;
    assign in_load  = !in_valid_reg || out_load;
    assign in_stall = !in_load;

    assign in_valid_next  = in_load ? in_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            number_reg <= number;
        end
    end

    // Conversion between the two registers.
    ssd_encode u_encode (
        .number (number_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign seg_first    = result_reg.seg_first;
    assign seg_second   = result_reg.seg_second;
    assign seg_third    = result_reg.seg_third;
    assign seg_fourth   = result_reg.seg_fourth;
    assign out_of_range = result_reg.out_of_range;

    // An accepted word is held in the input stage on the next cycle.
    `SSD_ASSERT_NEXT(a_in_captured, in_valid && !in_stall, in_valid_reg)
    // A word leaving the input stage shows up as a result on the next cycle.
    `SSD_ASSERT_NEXT(a_result_follows, in_valid_reg && out_load, out_valid_reg)
    // An out-of-range result shows all digits blank.
    `SSD_ASSERT_NOW(a_range_blank, out_valid_reg && result_reg.out_of_range,
        (result_reg.seg_first == SEG_BLANK) && (result_reg.seg_second == SEG_BLANK) &&
        (result_reg.seg_third == SEG_BLANK) && (result_reg.seg_fourth == SEG_BLANK))
    // The units digit is never blanked for an in-range number.
    `SSD_ASSERT_NOW(a_units_shown, out_valid_reg && !result_reg.out_of_range,
        result_reg.seg_fourth[6:0] != 7'd0)

endmodule

>>> rtl/ssd_encode.sv
// Combinational conversion of one signed number into four segment bytes.
module ssd_encode (
    input  logic signed [15:0] number,
    input  ssd_pkg::ssd_cfg_t  cfg,
    output ssd_pkg::ssd_result_t result
);
    import ssd_pkg::*;

    logic             neg;
    logic             range_err;
    logic [15:0]      abs_full;
    logic [MAG_W-1:0] mag;
    logic [PROD_W-1:0] p1000;
    logic [PROD_W-1:0] p100;
    logic [PROD_W-1:0] p10;
    logic [3:0]       q1000;
    logic [6:0]       q100;
    logic [9:0]       q10;
    logic [6:0]       rem100;
    logic [9:0]       rem10;
    logic [MAG_W-1:0] rem1;
    logic [3:0]       dig [4];
    logic [3:0]       blank;
    logic [7:0]       seg [4];
    logic [7:0]       seg_pt [4];

    // Sign, range check and magnitude.
    assign neg       = number[15];
    assign range_err = (number > 16'sd9999) || (number < -16'sd999);
    assign abs_full  = neg ? 16'(-number) : number;
    assign mag       = abs_full[MAG_W-1:0];

    // Quotients by reciprocal multiplication, all in parallel.
    assign p1000 = PROD_W'(mag) * PROD_W'(RECIP_1000);
    assign p100  = PROD_W'(mag) * PROD_W'(RECIP_100);
    assign p10   = PROD_W'(mag) * PROD_W'(RECIP_10);
    assign q1000 = p1000[27:24];
    assign q100  = p100[25:19];
    assign q10   = p10[25:16];

    // Lower digits: each quotient minus ten times the next coarser one.
    assign rem100 = q100 - 7'(q1000) * 7'd10;
    assign rem10  = q10 - 10'(q100) * 10'd10;
    assign rem1   = mag - MAG_W'(q10) * MAG_W'(10);

    assign dig[0] = q1000;
    assign dig[1] = rem100[3:0];
    assign dig[2] = rem10[3:0];
    assign dig[3] = rem1[3:0];

    // Leading-zero blanking; the minus sign and the units digit always show.
    assign blank[0] = !neg && cfg.blank_leading_zeros && (dig[0] == 4'd0);
    assign blank[1] = cfg.blank_leading_zeros && (dig[1] == 4'd0) && (neg || blank[0]);
    assign blank[2] = blank[1] && (dig[2] == 4'd0);
    assign blank[3] = 1'b0;

    // Segment patterns, point on shown digits if all_points, and on the chosen one.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (blank[i])
            begin
                seg[i] = SEG_BLANK;
            end
            else
            begin
                seg[i] = (i == 0 && neg) ? SEG_MINUS : digit_to_seg(dig[i]);
                if (cfg.all_points)
                begin
                    seg[i] = seg[i] | SEG_POINT;
                end
            end
            if (cfg.dp_position != DP_NONE && cfg.dp_position == 2'(i))
            begin
                seg_pt[i] = seg[i] | SEG_POINT;
            end
            else
            begin
                seg_pt[i] = seg[i];
            end
        end
    end

    // Out-of-range numbers show nothing.
    assign result.seg_first    = range_err ? SEG_BLANK : seg_pt[0];
    assign result.seg_second   = range_err ? SEG_BLANK : seg_pt[1];
    assign result.seg_third    = range_err ? SEG_BLANK : seg_pt[2];
    assign result.seg_fourth   = range_err ? SEG_BLANK : seg_pt[3];
    assign result.out_of_range = range_err;

endmodule

>>> dv/segment_word_checker.sv
// Checker that predicts and compares the segment words of the seven-segment encoder.
`timescale 1ns / 1ps

module segment_word_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] number,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         seg_first,
    input  logic [7:0]         seg_second,
    input  logic [7:0]         seg_third,
    input  logic [7:0]         seg_fourth,
    input  logic               out_of_range,
    output int                 mismatch_count,
    output int                 words_awaited
);
    import ssd_pkg::*;

    // Digit codes beside 0..9 used while building a display word.
    localparam int CODE_MINUS = 10;
    localparam int CODE_BLANK = 11;

    ssd_cfg_t    shown_cfg;
    ssd_result_t awaited_words[$];
    ssd_result_t got_word;
    ssd_result_t want_word;

    // Segment pattern of one decimal digit, XGFEDCBA.
    function automatic logic [7:0] digit_pattern(input int digit);
        logic [7:0] pattern;
        unique case (digit)
            0:       pattern = 8'h3f;
            1:       pattern = 8'h06;
            2:       pattern = 8'h5b;
            3:       pattern = 8'h4f;
            4:       pattern = 8'h66;
            5:       pattern = 8'h6d;
            6:       pattern = 8'h7d;
            7:       pattern = 8'h07;
            8:       pattern = 8'h7f;
            default: pattern = 8'h6f;
        endcase
        return pattern;
    endfunction

    // Four segment bytes and the range flag that a number should show.
    function automatic ssd_result_t display_word(input logic signed [15:0] value,
                                                 input ssd_cfg_t cfg);
        int          v;
        int          mag;
        int          code [4];
        logic [7:0]  seg [4];
        logic        leading;
        ssd_result_t word;
        v    = value;
        word = '0;
        if (v > 9999 || v < -999)
        begin
            word.out_of_range = 1'b1;
            return word;
        end
        if (v < 0)
        begin
            // Minus sign first, then the three low digits of the magnitude.
            mag     = -v;
            code[0] = CODE_MINUS;
            code[1] = mag / 100;
            code[2] = (mag / 10) % 10;
            code[3] = mag % 10;
            if (cfg.blank_leading_zeros && code[1] == 0)
            begin
                code[1] = CODE_BLANK;
                if (code[2] == 0)
                    code[2] = CODE_BLANK;
            end
        end
        else
        begin
            mag     = v;
            code[0] = mag / 1000;
            code[1] = (mag / 100) % 10;
            code[2] = (mag / 10) % 10;
            code[3] = mag % 10;
            // Blank zeros from the left until the first nonzero digit; units stay.
            leading = cfg.blank_leading_zeros;
            for (int i = 0; i < 3; i++)
            begin
                if (leading && code[i] == 0)
                    code[i] = CODE_BLANK;
                else
                    leading = 1'b0;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (code[i] == CODE_BLANK)
            begin
                seg[i] = SEG_BLANK;
            end
            else
            begin
                seg[i] = (code[i] == CODE_MINUS) ? SEG_MINUS : digit_pattern(code[i]);
                if (cfg.all_points)
                    seg[i] = seg[i] | SEG_POINT;
            end
        end
        // The chosen decimal point is set even on a blank digit.
        if (cfg.dp_position != DP_NONE)
            seg[cfg.dp_position] = seg[cfg.dp_position] | SEG_POINT;
        word.seg_first  = seg[0];
        word.seg_second = seg[1];
        word.seg_third  = seg[2];
        word.seg_fourth = seg[3];
        return word;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_cfg.blank_leading_zeros = 1'b1;
            shown_cfg.all_points          = 1'b1;
            shown_cfg.dp_position         = DP_NONE;
            awaited_words.delete();
            mismatch_count = 0;
            words_awaited  = 0;
        end
        else
        begin
            // Compare each delivered word with the oldest one awaited.
            if (out_valid && !out_stall)
            begin
                got_word.seg_first    = seg_first;
                got_word.seg_second   = seg_second;
                got_word.seg_third    = seg_third;
                got_word.seg_fourth   = seg_fourth;
                got_word.out_of_range = out_of_range;
                if (awaited_words.size() == 0)
                begin
                    $error("word delivered with none awaited: %0h", got_word);
                    mismatch_count++;
                end
                else
                begin
                    want_word = awaited_words.pop_front();
                    check_field("seg_first", want_word.seg_first, got_word.seg_first);
                    check_field("seg_second", want_word.seg_second, got_word.seg_second);
                    check_field("seg_third", want_word.seg_third, got_word.seg_third);
                    check_field("seg_fourth", want_word.seg_fourth, got_word.seg_fourth);
                    check_field("out_of_range", {7'b0, want_word.out_of_range},
                                {7'b0, got_word.out_of_range});
                end
            end
            // Each accepted number adds one awaited word.
            if (in_valid && !in_stall)
                awaited_words.push_back(display_word(number, shown_cfg));
            // Track register writes; written data is masked to the register width.
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BLANK_LEADING_ZEROS: shown_cfg.blank_leading_zeros = cfg_data[0];
                    REG_ALL_POINTS:          shown_cfg.all_points = cfg_data[0];
                    REG_DP_POSITION:         shown_cfg.dp_position = cfg_data;
                    default:                 ;
                endcase
            end
            words_awaited = awaited_words.size();
        end
    end

endmodule

>>> dv/signed_number_to_seven_segment_core_test.sv
// Testbench top for the seven-segment encoder: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module signed_number_to_seven_segment_core_test;
    import ssd_pkg::*;

    // Index that names no register; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         WORDS_PER_SET = 170;
    localparam int         SET_COUNT    = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [1:0]         cfg_data = 2'd0;
    logic               in_valid = 1'b0;
    logic signed [15:0] number = 16'sd0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [7:0]         seg_first;
    logic [7:0]         seg_second;
    logic [7:0]         seg_third;
    logic [7:0]         seg_fourth;
    logic               out_of_range;

    int mismatch_count;
    int words_awaited;
    int send_idle_pct = 24;
    int stall_pct = 49;
    int quiet_cycles = 0;
    int corner_values [0:23];
    int blank_sets [0:5];
    int point_sets [0:5];
    int dp_sets [0:5];

    always #2 clk = ~clk;

    signed_number_to_seven_segment_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .number       (number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .seg_first    (seg_first),
        .seg_second   (seg_second),
        .seg_third    (seg_third),
        .seg_fourth   (seg_fourth),
        .out_of_range (out_of_range)
    );

    segment_word_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .number         (number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seg_first      (seg_first),
        .seg_second     (seg_second),
        .seg_third      (seg_third),
        .seg_fourth     (seg_fourth),
        .out_of_range   (out_of_range),
        .mismatch_count (mismatch_count),
        .words_awaited  (words_awaited)
    );

    // Receiver backpressure at the current rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("signed_number_to_seven_segment_core_test: FAIL");
        $finish;
    end

    // Offer one number and hold it until the encoder takes it.
    task automatic send_number(input logic [15:0] value);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    // Stop offering and let every awaited word drain, plus the pipeline depth.
    // The count is read away from the rising edge, after the checker has updated it.
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (words_awaited != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers back to back; the upper data bit of the one-bit
    // registers is noise that must be masked off.
    task automatic set_registers(input int blank, input int point, input int dp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= 2'($urandom_range(3));
        @(posedge clk);
        cfg_index <= REG_BLANK_LEADING_ZEROS;
        cfg_data  <= {1'($urandom_range(1)), 1'(blank)};
        @(posedge clk);
        cfg_index <= REG_ALL_POINTS;
        cfg_data  <= {1'($urandom_range(1)), 1'(point)};
        @(posedge clk);
        cfg_index <= REG_DP_POSITION;
        cfg_data  <= 2'(dp);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly in-range numbers, weighted toward short ones, with full-range noise.
    function automatic logic [15:0] pick_number();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 30)
            v = $urandom_range(9999, 0);
        else if (sel < 50)
            v = -int'($urandom_range(999, 1));
        else if (sel < 62)
            v = $urandom_range(120, 0);
        else if (sel < 72)
            v = -int'($urandom_range(120, 1));
        else if (sel < 77)
            v = 10000 + int'($urandom_range(40));
        else if (sel < 82)
            v = -1000 - int'($urandom_range(40));
        else
            v = $urandom_range(65535);
        return v[15:0];
    endfunction

    initial
    begin
        corner_values = '{0, 1, 9, 10, 100, 1000, 9999, 10000, -1, -9, -10, -99,
                          -100, -999, -1000, 32767, -32768, 5, 105, 1005, -5, -105,
                          1234, 5678};
        blank_sets = '{0, 1, 0, 1, 0, 1};
        point_sets = '{0, 0, 1, 1, 0, 1};
        dp_sets    = '{0, 3, 1, 2, 3, 0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Boundaries, blanking cases and out-of-range values under reset settings.
        foreach (corner_values[i])
            send_number(corner_values[i][15:0]);
        drain();

        for (int s = 0; s < SET_COUNT; s++)
        begin
            if (s == 2)
            begin
                send_idle_pct = 49;
                stall_pct     = 24;
            end
            else if (s == 4)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            set_registers(blank_sets[s], point_sets[s], dp_sets[s]);
            // A few boundary words under every setting, then random ones.
            send_number(16'sd0);
            send_number(-16'sd7);
            send_number(16'sd9999);
            repeat (WORDS_PER_SET)
                send_number(pick_number());
            drain();
        end

        if (mismatch_count == 0)
            $display("signed_number_to_seven_segment_core_test: PASS");
        else
            $display("signed_number_to_seven_segment_core_test: FAIL");
        $finish;
    end

endmodule

>>> signed_number_to_seven_segment_core.f
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_encode.sv
rtl/signed_number_to_seven_segment_core.sv
dv/segment_word_checker.sv
dv/signed_number_to_seven_segment_core_test.sv
